[rtl/scm_pkg.sv]
package scm_pkg;

  localparam int MAX_CHUNKS = 1024;
  localparam int IDX_W = $clog2(MAX_CHUNKS);
  localparam int CNT_W = IDX_W + 1;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_BAD    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_FAILED = 3'd4;

  // content kinds
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_RAW  = 2'd2;

  // chunk type codes
  localparam logic [15:0] CODE_RAW  = 16'hCAC1;
  localparam logic [15:0] CODE_FILL = 16'hCAC2;
  localparam logic [15:0] CODE_DC   = 16'hCAC3;
  localparam logic [15:0] CODE_CRC  = 16'hCAC4;

  localparam logic [16:0] BLOCK_SIZE_MAX = 17'd65536;
  localparam logic [31:0] WORD_BYTES     = 32'd4;

  // config register indexes and reset values
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] REG_TOTAL       = 2'd1;
  localparam logic [1:0] REG_FILE_HDR    = 2'd2;
  localparam logic [1:0] REG_CHUNK_HDR   = 2'd3;
  localparam logic [16:0] RST_BLOCK_SIZE = 17'd4096;
  localparam logic [31:0] RST_TOTAL      = 32'd1;
  localparam logic [15:0] RST_FILE_HDR   = 16'd28;
  localparam logic [15:0] RST_CHUNK_HDR  = 16'd12;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] count;
    logic [1:0]  kind;
    logic [63:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LD_CHK,
    S_LK_TEST,
    S_LK_CMP,
    S_LK_ADD,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic ld_mul;
    logic ld_chk;
    logic lk_init;
    logic lk_rd;
    logic lk_cmp;
    logic lk_miss;
    logic lk_add;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       early;
    logic       lo_lt_hi;
    logic       hit;
    logic       out_free;
  } sts_t;

endpackage

[rtl/scm_ram.sv]
module scm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/scm_ctrl.sv]
module scm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  scm_pkg::sts_t   sts,
  output scm_pkg::cmd_t   cmd
);

  scm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = scm_pkg::S_DECODE;
      end
      scm_pkg::S_DECODE: begin
        case (sts.action)
          scm_pkg::ACT_CLEAR:  state_nxt = scm_pkg::S_DONE;
          scm_pkg::ACT_LOAD:   state_nxt = scm_pkg::S_LD_CHK;
          scm_pkg::ACT_LOOKUP: state_nxt = sts.early ? scm_pkg::S_DONE : scm_pkg::S_LK_TEST;
          default:             state_nxt = scm_pkg::S_IDLE;
        endcase
      end
      scm_pkg::S_LD_CHK:  state_nxt = scm_pkg::S_DONE;
      scm_pkg::S_LK_TEST: begin
        state_nxt = sts.lo_lt_hi ? scm_pkg::S_LK_CMP : scm_pkg::S_DONE;
      end
      scm_pkg::S_LK_CMP: begin
        state_nxt = sts.hit ? scm_pkg::S_LK_ADD : scm_pkg::S_LK_TEST;
      end
      scm_pkg::S_LK_ADD:  state_nxt = scm_pkg::S_DONE;
      scm_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = scm_pkg::S_IDLE;
      end
      default: state_nxt = scm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      scm_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      scm_pkg::S_DECODE: begin
        cmd.clear   = (sts.action == scm_pkg::ACT_CLEAR);
        cmd.ld_mul  = (sts.action == scm_pkg::ACT_LOAD);
        cmd.lk_init = (sts.action == scm_pkg::ACT_LOOKUP);
      end
      scm_pkg::S_LD_CHK: cmd.ld_chk = 1'b1;
      scm_pkg::S_LK_TEST: begin
        cmd.lk_rd   = sts.lo_lt_hi;
        cmd.lk_miss = !sts.lo_lt_hi;
      end
      scm_pkg::S_LK_CMP: cmd.lk_cmp = 1'b1;
      scm_pkg::S_LK_ADD: cmd.lk_add = 1'b1;
      scm_pkg::S_DONE:   cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/scm_dp.sv]
module scm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  scm_pkg::cmd_t cmd,
  output scm_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic [1:0]    in_action,
  input  logic [15:0]   in_chunk_kind_code,
  input  logic [31:0]   in_chunk_blocks,
  input  logic [31:0]   in_chunk_total_bytes,
  input  logic [31:0]   in_fill_word,
  input  logic [31:0]   in_block_address,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic [1:0]    out_content_kind,
  output logic [31:0]   out_fill_pattern,
  output logic [63:0]   out_raw_file_offset
);

  localparam int IW = scm_pkg::IDX_W;
  localparam int CW = scm_pkg::CNT_W;

  // configuration
  logic [16:0] block_size_r;
  logic [31:0] total_blocks_r;
  logic [15:0] file_hdr_r, chunk_hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= scm_pkg::RST_BLOCK_SIZE;
      total_blocks_r <= scm_pkg::RST_TOTAL;
      file_hdr_r     <= scm_pkg::RST_FILE_HDR;
      chunk_hdr_r    <= scm_pkg::RST_CHUNK_HDR;
    end else if (cfg_we) begin
      case (cfg_index)
        scm_pkg::REG_BLOCK_SIZE: block_size_r   <= cfg_data[16:0];
        scm_pkg::REG_TOTAL:      total_blocks_r <= cfg_data;
        scm_pkg::REG_FILE_HDR:   file_hdr_r     <= cfg_data[15:0];
        scm_pkg::REG_CHUNK_HDR:  chunk_hdr_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured word
  logic [1:0]  act_r;
  logic [15:0] code_r;
  logic [31:0] blocks_r, total_r, fill_r, blk_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_action;
      code_r   <= in_chunk_kind_code;
      blocks_r <= in_chunk_blocks;
      total_r  <= in_chunk_total_bytes;
      fill_r   <= in_fill_word;
      blk_r    <= in_block_address;
    end
  end

  // map state
  logic [CW-1:0] loaded_r;
  logic [31:0]   next_block_r;
  logic [63:0]   next_off_r;
  logic          failed_r;

  // search and result registers
  logic [CW-1:0] lo_r, hi_r;
  logic [48:0]   prod_r;
  logic [2:0]    res_status_r;
  logic [1:0]    res_kind_r;
  logic [31:0]   res_fill_r;
  logic [63:0]   res_off_r;
  scm_pkg::entry_t hit_r;

  // one shared multiplier: chunk blocks for load, relative block for lookup
  logic [31:0] mul_a;
  logic [31:0] rel;
  scm_pkg::entry_t rd_ent;
  assign rel   = blk_r - rd_ent.start;
  assign mul_a = cmd.lk_cmp ? rel : blocks_r;

  // RAM
  scm_pkg::entry_t wr_ent;
  logic [scm_pkg::ENTRY_W-1:0] rdata;
  logic [CW-1:0] mid;
  logic          ram_we;
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_ent = scm_pkg::entry_t'(rdata);

  scm_ram #(.WIDTH(scm_pkg::ENTRY_W), .DEPTH(scm_pkg::MAX_CHUNKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (loaded_r[IW-1:0]),
    .wdata (wr_ent),
    .re    (cmd.lk_rd),
    .raddr (mid[IW-1:0]),
    .rdata (rdata)
  );

  // load checks
  logic [31:0] payload;
  logic        hdr_bad, type_bad, full;
  logic [32:0] end_block;
  logic [1:0]  ld_kind;
  logic [63:0] ld_value;
  logic        is_crc;

  always_comb begin
    payload  = total_r - {16'd0, chunk_hdr_r};
    hdr_bad  = (total_r < {16'd0, chunk_hdr_r}) || (block_size_r == 17'd0) ||
               (block_size_r > scm_pkg::BLOCK_SIZE_MAX);
    is_crc   = (code_r == scm_pkg::CODE_CRC);
    ld_kind  = scm_pkg::KIND_ZERO;
    ld_value = 64'd0;
    type_bad = 1'b0;
    case (code_r)
      scm_pkg::CODE_CRC:  type_bad = (payload != scm_pkg::WORD_BYTES);
      scm_pkg::CODE_RAW: begin
        type_bad = ({17'd0, payload} != prod_r);
        ld_kind  = scm_pkg::KIND_RAW;
        ld_value = next_off_r + {48'd0, chunk_hdr_r};
      end
      scm_pkg::CODE_FILL: begin
        type_bad = (payload != scm_pkg::WORD_BYTES);
        ld_kind  = scm_pkg::KIND_FILL;
        ld_value = {32'd0, fill_r};
      end
      scm_pkg::CODE_DC: type_bad = (payload != 32'd0);
      default: type_bad = 1'b1;
    endcase
    end_block = {1'b0, next_block_r} + {1'b0, blocks_r};
    full      = (loaded_r >= CW'(scm_pkg::MAX_CHUNKS));
    wr_ent.start = next_block_r;
    wr_ent.count = blocks_r;
    wr_ent.kind  = ld_kind;
    wr_ent.value = ld_value;
  end

  logic ld_ok_entry;
  assign ld_ok_entry = !failed_r && !hdr_bad && !type_bad && !is_crc &&
                       (end_block <= {1'b0, total_blocks_r}) && !full;
  assign ram_we = cmd.ld_chk && ld_ok_entry;

  // lookup compare
  logic [32:0] ent_end;
  logic        hit, below;
  assign ent_end = {1'b0, rd_ent.start} + {1'b0, rd_ent.count};
  assign below   = blk_r < rd_ent.start;
  assign hit     = !below && ({1'b0, blk_r} < ent_end);

  logic early_fail;
  assign early_fail = failed_r || (blk_r >= total_blocks_r);

  // map state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r     <= '0;
      next_block_r <= '0;
      next_off_r   <= {48'd0, scm_pkg::RST_FILE_HDR};
      failed_r     <= 1'b0;
    end else if (cmd.clear) begin
      loaded_r     <= '0;
      next_block_r <= '0;
      next_off_r   <= {48'd0, file_hdr_r};
      failed_r     <= 1'b0;
    end else if (cmd.ld_chk && !failed_r) begin
      if (hdr_bad || type_bad) begin
        failed_r <= 1'b1;
      end else if (is_crc) begin
        next_off_r <= next_off_r + {32'd0, total_r};
      end else if (end_block > {1'b0, total_blocks_r} || full) begin
        failed_r <= 1'b1;
      end else begin
        loaded_r     <= loaded_r + CW'(1);
        next_block_r <= end_block[31:0];
        next_off_r   <= next_off_r + {32'd0, total_r};
      end
    end
  end

  // multiplier, search bounds, result
  always_ff @(posedge clk) begin
    if (cmd.ld_mul || cmd.lk_cmp) begin
      prod_r <= mul_a * block_size_r;
    end
    if (cmd.lk_cmp) begin
      hit_r <= rd_ent;
      if (!hit) begin
        if (below) hi_r <= mid;
        else       lo_r <= mid + CW'(1);
      end
    end else if (cmd.lk_init) begin
      lo_r <= '0;
      hi_r <= loaded_r;
    end
    // result status
    if (cmd.ld_chk) begin
      if (failed_r)                 res_status_r <= scm_pkg::ST_FAILED;
      else if (hdr_bad || type_bad) res_status_r <= scm_pkg::ST_BAD;
      else if (is_crc)              res_status_r <= scm_pkg::ST_OK;
      else if (end_block > {1'b0, total_blocks_r}) res_status_r <= scm_pkg::ST_BAD;
      else if (full)                res_status_r <= scm_pkg::ST_FULL;
      else                          res_status_r <= scm_pkg::ST_OK;
    end else if (cmd.lk_init) begin
      if (failed_r)         res_status_r <= scm_pkg::ST_FAILED;
      else if (early_fail)  res_status_r <= scm_pkg::ST_RANGE;
      else                  res_status_r <= scm_pkg::ST_OK;
    end else if (cmd.clear || cmd.lk_miss || cmd.lk_add) begin
      res_status_r <= scm_pkg::ST_OK;
    end
    // result content
    if (cmd.lk_add) begin
      case (hit_r.kind)
        scm_pkg::KIND_RAW: begin
          res_kind_r <= scm_pkg::KIND_RAW;
          res_fill_r <= '0;
          res_off_r  <= hit_r.value + {15'd0, prod_r};
        end
        scm_pkg::KIND_FILL: begin
          res_kind_r <= scm_pkg::KIND_FILL;
          res_fill_r <= hit_r.value[31:0];
          res_off_r  <= '0;
        end
        default: begin
          res_kind_r <= scm_pkg::KIND_ZERO;
          res_fill_r <= '0;
          res_off_r  <= '0;
        end
      endcase
    end else if (cmd.clear || cmd.ld_chk || cmd.lk_init || cmd.lk_miss) begin
      res_kind_r <= scm_pkg::KIND_ZERO;
      res_fill_r <= '0;
      res_off_r  <= '0;
    end
  end

  // output register
  logic out_valid_r;
  logic [2:0]  out_status_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_fill_r;
  logic [63:0] out_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_kind_r   <= res_kind_r;
      out_fill_r   <= res_fill_r;
      out_off_r    <= res_off_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_content_kind    = out_kind_r;
  assign out_fill_pattern    = out_fill_r;
  assign out_raw_file_offset = out_off_r;

  assign sts.action   = act_r;
  assign sts.early    = early_fail;
  assign sts.lo_lt_hi = lo_r < hi_r;
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

[rtl/sparse_image_chunk_map_top.sv]
// Sparse image block map: one word at a time.
// Clear: decode, then out. Load: multiply, check and write, out. Lookup: a binary search, each
// probe one registered table read plus a compare (up to 11 probes for 1024 entries), an add on
// a hit, then out; failed or out of range goes straight out. A held result stalls the output
// stage; the next word is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous): config to defaults, map empty, not failed, no result held.
module sparse_image_chunk_map_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_chunk_kind_code,
  input  logic [31:0] in_chunk_blocks,
  input  logic [31:0] in_chunk_total_bytes,
  input  logic [31:0] in_fill_word,
  input  logic [31:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_content_kind,
  output logic [31:0] out_fill_pattern,
  output logic [63:0] out_raw_file_offset
);

  scm_pkg::cmd_t cmd;
  scm_pkg::sts_t sts;

  scm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_action            (in_action),
    .in_chunk_kind_code   (in_chunk_kind_code),
    .in_chunk_blocks      (in_chunk_blocks),
    .in_chunk_total_bytes (in_chunk_total_bytes),
    .in_fill_word         (in_fill_word),
    .in_block_address     (in_block_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_content_kind     (out_content_kind),
    .out_fill_pattern     (out_fill_pattern),
    .out_raw_file_offset  (out_raw_file_offset)
  );

  // one word in flight: stall rises right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // error results carry no content
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != scm_pkg::ST_OK) |->
      (out_content_kind == scm_pkg::KIND_ZERO) && (out_raw_file_offset == 64'd0))
    else $error("content on error result");

  // offset only for raw, fill word only for fill
  a_raw_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_content_kind != scm_pkg::KIND_RAW) |-> out_raw_file_offset == 64'd0)
    else $error("offset on non-raw result");

  a_fill_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_content_kind != scm_pkg::KIND_FILL) |-> out_fill_pattern == 32'd0)
    else $error("fill word on non-fill result");

endmodule
